>>> rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    // Default heap depth in 32-bit words (a power of two).
    localparam int FFHA_HEAP_WORDS = 16384;

    // Boundary tag fields and layout constants.
    localparam logic [31:0] SIZE_MASK        = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT        = 32'h0000_0001;
    localparam logic [31:0] MIN_BLOCK        = 32'd16;
    localparam logic [31:0] INIT_CHUNK       = 32'd4096;
    localparam logic [31:0] PROLOGUE_PAYLOAD = 32'd8;
    localparam logic [31:0] FIRST_PAYLOAD    = 32'd24;
    localparam logic [16:0] EXT_RESET        = 17'd4096;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // One memory access request, addressed in bytes.
    typedef struct packed {
        logic        re;
        logic [31:0] raddr;
        logic        we;
        logic [31:0] waddr;
        logic [31:0] wdata;
    } t_mem_req;

    // One result transfer.
    typedef struct packed {
        logic        done;
        logic [15:0] addr;
        logic        status;
    } t_result;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_A_RDH, S_A_HDR, S_A_NXT,
        S_G_SIZE, S_G_CHK, S_G_W2, S_G_W3,
        S_M_RD0, S_M_SZ, S_M_PRV, S_M_NXT,
        S_M_A2, S_M_A3,
        S_M_B1, S_M_B2, S_M_B3, S_M_B4,
        S_M_C1, S_M_C2, S_M_C3, S_M_C4, S_M_END,
        S_C_RD, S_C_SZ, S_C_SPLIT, S_C_W2, S_C_W3, S_C_W4, S_C_W7, S_C_END,
        S_U_RD, S_U_PRV, S_U_NXT, S_U_FIX,
        S_P_W1, S_P_W2, S_P_W3,
        S_F_HDR, S_F_FTR, S_F_W2
    } t_state;

endpackage

>>> rtl/ffha_ram.sv
// Heap word memory: one write port and one registered read port.
`timescale 1ns / 1ps
module ffha_ram
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = FFHA_HEAP_WORDS
) (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);

    localparam int AW = $clog2(HEAP_WORDS);

    logic [31:0] r_mem [HEAP_WORDS];
    logic [31:0] r_rdata;

    // Byte addresses wrap onto the word array.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW+1:2]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW+1:2]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ffha_ctrl.sv
// Allocator sequencer: list walk, split, growth, coalescing and list updates.
`timescale 1ns / 1ps
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = FFHA_HEAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_operation,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_block_address,
    input  logic [16:0] i_ext,
    input  logic [31:0] i_rdata,
    output t_mem_req    o_mem,
    output logic        o_busy,
    output t_result     o_result
);

    localparam int          AW         = $clog2(HEAP_WORDS);
    localparam logic [31:0] HEAP_BYTES = 32'(HEAP_WORDS * 4);
    localparam bit          FITS       = (HEAP_WORDS * 4 - 24) >= 4096;
    localparam logic [31:0] HEAD_RST   = FITS ? FIRST_PAYLOAD : PROLOGUE_PAYLOAD;
    localparam logic [31:0] BRK_RST    = FITS ? 32'd4120 : 32'd24;

    // Word written by the clearing pass: the reset layout of the heap.
    function automatic logic [31:0] init_word(input logic [AW-1:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx == AW'(1) || idx == AW'(4)) begin
            v = MIN_BLOCK | ALLOC_BIT;
        end else if (FITS) begin
            if (idx == AW'(3)) begin
                v = FIRST_PAYLOAD;
            end else if (idx == AW'(5) || idx == AW'(1028)) begin
                v = INIT_CHUNK;
            end else if (idx == AW'(6)) begin
                v = PROLOGUE_PAYLOAD;
            end else if (idx == AW'(1029)) begin
                v = ALLOC_BIT;
            end
        end else if (idx == AW'(5)) begin
            v = ALLOC_BIT;
        end
        return v;
    endfunction

    t_state        r_state, n_state;
    t_state        r_ret, n_ret;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_op, n_op;
    logic [31:0]   r_asize, n_asize;
    logic [31:0]   r_bp, n_bp;
    logic [31:0]   r_sz, n_sz;
    logic [31:0]   r_h, n_h;
    logic [31:0]   r_csize, n_csize;
    logic [31:0]   r_pbp, n_pbp;
    logic [31:0]   r_nbp, n_nbp;
    logic [31:0]   r_nsz, n_nsz;
    logic [31:0]   r_nend, n_nend;
    logic          r_pa, n_pa;
    logic [31:0]   r_ul, n_ul;
    logic [31:0]   r_pu, n_pu;
    logic [31:0]   r_prv, n_prv;
    logic [31:0]   r_nxt, n_nxt;
    logic [31:0]   r_fh, n_fh;
    logic [31:0]   r_brk, n_brk;
    t_result       r_res, n_res;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fh    <= HEAD_RST;
            r_brk   <= BRK_RST;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fh    <= n_fh;
            r_brk   <= n_brk;
            r_res   <= n_res;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_cnt   <= n_cnt;
        r_op    <= n_op;
        r_asize <= n_asize;
        r_bp    <= n_bp;
        r_sz    <= n_sz;
        r_h     <= n_h;
        r_csize <= n_csize;
        r_pbp   <= n_pbp;
        r_nbp   <= n_nbp;
        r_nsz   <= n_nsz;
        r_nend  <= n_nend;
        r_pa    <= n_pa;
        r_ul    <= n_ul;
        r_pu    <= n_pu;
        r_prv   <= n_prv;
        r_nxt   <= n_nxt;
    end

    // Next state, memory requests and results.
    always_comb begin
        logic [31:0] a;
        logic [31:0] msz;
        logic [31:0] grow_by;
        logic [31:0] words;
        logic [31:0] diff;
        n_state = r_state;
        n_ret   = r_ret;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_asize = r_asize;
        n_bp    = r_bp;
        n_sz    = r_sz;
        n_h     = r_h;
        n_csize = r_csize;
        n_pbp   = r_pbp;
        n_nbp   = r_nbp;
        n_nsz   = r_nsz;
        n_nend  = r_nend;
        n_pa    = r_pa;
        n_ul    = r_ul;
        n_pu    = r_pu;
        n_prv   = r_prv;
        n_nxt   = r_nxt;
        n_fh    = r_fh;
        n_brk   = r_brk;
        n_res   = '0;
        o_mem   = '0;
        msz     = i_rdata & SIZE_MASK;
        a       = 32'(i_block_address);
        grow_by = (r_asize > 32'(i_ext)) ? r_asize : 32'(i_ext);
        words   = grow_by >> 2;
        diff    = r_csize - r_asize;
        case (r_state)
            // Write the reset layout over the whole memory.
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = 32'(r_clr) << 2;
                o_mem.wdata = init_word(r_clr);
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(HEAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_operation;
                    if (i_operation == OP_ALLOC) begin
                        if (i_request_size == 17'd0) begin
                            n_res = '{done: 1'b1, addr: 16'd0, status: ST_FAIL};
                        end else begin
                            n_asize = (32'(i_request_size) + 32'd15) & SIZE_MASK;
                            n_bp    = r_fh;
                            n_cnt   = '0;
                            n_state = S_A_RDH;
                        end
                    end else if (a[2:0] != 3'd0 || a < FIRST_PAYLOAD || a >= r_brk) begin
                        n_res = '{done: 1'b1, addr: 16'd0, status: ST_DONE};
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = a - 32'd4;
                        n_bp        = a;
                        n_state     = S_F_HDR;
                    end
                end
            end
            // First-fit walk over the free list.
            S_A_RDH: begin
                if (r_cnt == (AW+1)'(HEAP_WORDS)) begin
                    n_state = S_G_SIZE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_bp - 32'd4;
                    n_state     = S_A_HDR;
                end
            end
            S_A_HDR: begin
                if (i_rdata[0]) begin
                    n_state = S_G_SIZE;
                end else if (msz >= r_asize) begin
                    n_state = S_C_RD;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_bp;
                    n_state     = S_A_NXT;
                end
            end
            S_A_NXT: begin
                n_bp    = i_rdata;
                n_cnt   = r_cnt + (AW+1)'(1);
                n_state = S_A_RDH;
            end
            // Heap growth.
            S_G_SIZE: begin
                n_sz    = (words + {31'd0, words[0]}) << 2;
                n_state = S_G_CHK;
            end
            S_G_CHK: begin
                if (r_sz > HEAP_BYTES - r_brk) begin
                    n_res   = '{done: 1'b1, addr: 16'd0, status: ST_FAIL};
                    n_state = S_IDLE;
                end else begin
                    n_bp        = r_brk;
                    n_brk       = r_brk + r_sz;
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_brk - 32'd4;
                    o_mem.wdata = r_sz;
                    n_state     = S_G_W2;
                end
            end
            S_G_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_sz - 32'd8;
                o_mem.wdata = r_sz;
                n_state     = S_G_W3;
            end
            S_G_W3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_sz - 32'd4;
                o_mem.wdata = ALLOC_BIT;
                n_state     = S_M_RD0;
            end
            // Coalescing with neighbors.
            S_M_RD0: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_bp - 32'd4;
                n_state     = S_M_SZ;
            end
            S_M_SZ: begin
                n_sz        = msz;
                o_mem.re    = 1'b1;
                o_mem.raddr = r_bp - 32'd8;
                n_state     = S_M_PRV;
            end
            S_M_PRV: begin
                n_pa        = i_rdata[0];
                n_pbp       = r_bp - msz;
                n_nbp       = r_bp + r_sz;
                o_mem.re    = 1'b1;
                o_mem.raddr = r_bp + r_sz - 32'd4;
                n_state     = S_M_NXT;
            end
            S_M_NXT: begin
                if (r_pa && !i_rdata[0]) begin
                    n_sz    = r_sz + msz;
                    n_ul    = r_nbp;
                    n_ret   = S_M_A2;
                    n_state = S_U_RD;
                end else if (!r_pa && i_rdata[0]) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_pbp - 32'd4;
                    n_state     = S_M_B1;
                end else if (!r_pa) begin
                    n_nend      = r_nbp + msz - 32'd8;
                    n_nsz       = msz;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_pbp - 32'd4;
                    n_state     = S_M_C1;
                end else begin
                    n_pu    = r_bp;
                    n_ret   = S_M_END;
                    n_state = S_P_W1;
                end
            end
            S_M_A2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp - 32'd4;
                o_mem.wdata = r_sz;
                n_state     = S_M_A3;
            end
            S_M_A3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_sz - 32'd8;
                o_mem.wdata = r_sz;
                n_pu        = r_bp;
                n_ret       = S_M_END;
                n_state     = S_P_W1;
            end
            S_M_B1: begin
                n_sz    = r_sz + msz;
                n_ul    = r_pbp;
                n_ret   = S_M_B2;
                n_state = S_U_RD;
            end
            S_M_B2: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_bp - 32'd4;
                n_state     = S_M_B3;
            end
            S_M_B3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + msz - 32'd8;
                o_mem.wdata = r_sz;
                n_state     = S_M_B4;
            end
            S_M_B4: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pbp - 32'd4;
                o_mem.wdata = r_sz;
                n_bp        = r_pbp;
                n_pu        = r_pbp;
                n_ret       = S_M_END;
                n_state     = S_P_W1;
            end
            S_M_C1: begin
                n_sz    = r_sz + msz + r_nsz;
                n_ul    = r_pbp;
                n_ret   = S_M_C2;
                n_state = S_U_RD;
            end
            S_M_C2: begin
                n_ul    = r_nbp;
                n_ret   = S_M_C3;
                n_state = S_U_RD;
            end
            S_M_C3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pbp - 32'd4;
                o_mem.wdata = r_sz;
                n_state     = S_M_C4;
            end
            S_M_C4: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_nend;
                o_mem.wdata = r_sz;
                n_bp        = r_pbp;
                n_pu        = r_pbp;
                n_ret       = S_M_END;
                n_state     = S_P_W1;
            end
            S_M_END: begin
                if (r_op == OP_FREE) begin
                    n_res   = '{done: 1'b1, addr: 16'd0, status: ST_DONE};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_C_RD;
                end
            end
            // Take the chosen block, splitting off a free remainder when it is large enough.
            S_C_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_bp - 32'd4;
                n_state     = S_C_SZ;
            end
            S_C_SZ: begin
                n_csize = msz;
                n_ul    = r_bp;
                n_ret   = S_C_SPLIT;
                n_state = S_U_RD;
            end
            S_C_SPLIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp - 32'd4;
                if (diff >= MIN_BLOCK) begin
                    o_mem.wdata = r_asize | ALLOC_BIT;
                    n_state     = S_C_W2;
                end else begin
                    o_mem.wdata = r_csize | ALLOC_BIT;
                    n_state     = S_C_W7;
                end
            end
            S_C_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_asize - 32'd8;
                o_mem.wdata = r_asize | ALLOC_BIT;
                n_state     = S_C_W3;
            end
            S_C_W3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_asize - 32'd4;
                o_mem.wdata = diff;
                n_state     = S_C_W4;
            end
            S_C_W4: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_asize + diff - 32'd8;
                o_mem.wdata = diff;
                n_pu        = r_bp + r_asize;
                n_ret       = S_C_END;
                n_state     = S_P_W1;
            end
            S_C_W7: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_csize - 32'd8;
                o_mem.wdata = r_csize | ALLOC_BIT;
                n_res       = '{done: 1'b1, addr: r_bp[15:0], status: ST_DONE};
                n_state     = S_IDLE;
            end
            S_C_END: begin
                n_res   = '{done: 1'b1, addr: r_bp[15:0], status: ST_DONE};
                n_state = S_IDLE;
            end
            // Remove a block from the free list.
            S_U_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_ul + 32'd4;
                n_state     = S_U_PRV;
            end
            S_U_PRV: begin
                n_prv       = i_rdata;
                o_mem.re    = 1'b1;
                o_mem.raddr = r_ul;
                n_state     = S_U_NXT;
            end
            S_U_NXT: begin
                n_nxt = i_rdata;
                if (r_prv != 32'd0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_prv;
                    o_mem.wdata = i_rdata;
                end else begin
                    n_fh = i_rdata;
                end
                n_state = S_U_FIX;
            end
            S_U_FIX: begin
                if (r_nxt != 32'd0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_nxt + 32'd4;
                    o_mem.wdata = r_prv;
                end
                n_state = r_ret;
            end
            // Push a block at the list head.
            S_P_W1: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pu + 32'd4;
                o_mem.wdata = 32'd0;
                n_state     = S_P_W2;
            end
            S_P_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pu;
                o_mem.wdata = r_fh;
                n_state     = S_P_W3;
            end
            S_P_W3: begin
                if (r_fh != 32'd0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_fh + 32'd4;
                    o_mem.wdata = r_pu;
                end
                n_fh    = r_pu;
                n_state = r_ret;
            end
            // Validate a block being released and mark its tags free.
            S_F_HDR: begin
                n_h  = i_rdata;
                n_sz = msz;
                if (!i_rdata[0] || msz < MIN_BLOCK || msz > r_brk - r_bp) begin
                    n_res   = '{done: 1'b1, addr: 16'd0, status: ST_DONE};
                    n_state = S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_bp + msz - 32'd8;
                    n_state     = S_F_FTR;
                end
            end
            S_F_FTR: begin
                if (i_rdata != r_h) begin
                    n_res   = '{done: 1'b1, addr: 16'd0, status: ST_DONE};
                    n_state = S_IDLE;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_bp - 32'd4;
                    o_mem.wdata = r_sz;
                    n_state     = S_F_W2;
                end
            end
            S_F_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_bp + r_sz - 32'd8;
                o_mem.wdata = r_sz;
                n_state     = S_M_RD0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_res;

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator with its configuration register.
// A free checks its tags and coalesces; an allocate walks the free list first
// fit and grows the heap when no listed block fits. One item at a time; busy
// is high from the cycle after acceptance until the result strobe, though a
// zero-size allocate or a rejected free address gives the strobe with busy
// low. After reset a clearing pass writes the initial heap layout over all
// HEAP_WORDS words with busy high; the result strobe cannot be stalled.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = FFHA_HEAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_block_address,
    output logic        o_done,
    output logic [15:0] o_result_address,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_extend_chunk_bytes
);

    logic [16:0] r_ext;
    t_mem_req    mem_req;
    logic [31:0] mem_rdata;
    t_result     result;

    // Growth chunk register, written by a configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= EXT_RESET;
        end else if (i_cfg_valid) begin
            r_ext <= i_extend_chunk_bytes;
        end
    end

    assign o_cfg_ready = 1'b1;

    ffha_ram #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_rdata)
    );

    ffha_ctrl #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_block_address(i_block_address),
        .i_ext          (r_ext),
        .i_rdata        (mem_rdata),
        .o_mem          (mem_req),
        .o_busy         (busy),
        .o_result       (result)
    );

    assign o_done           = result.done;
    assign o_result_address = result.addr;
    assign o_status         = result.status;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 1ps
module tb_top;
    import ffha_pkg::*;

    localparam int HW = FFHA_HEAP_WORDS;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 4 * (RANDOM_ITEMS + 100) * (3 * HW + 64);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [16:0] i_request_size;
    logic [15:0] i_block_address;
    logic        o_done;
    logic [15:0] o_result_address;
    logic        o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_extend_chunk_bytes;

    first_fit_heap_allocator_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_operation          (i_operation),
        .i_request_size       (i_request_size),
        .i_block_address      (i_block_address),
        .o_done               (o_done),
        .o_result_address     (o_result_address),
        .o_status             (o_status),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_extend_chunk_bytes (i_extend_chunk_bytes)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the heap and allocator registers.
    logic [31:0] heap_shadow [HW];
    logic [31:0] shadow_head;
    logic [31:0] shadow_break;
    logic [31:0] shadow_chunk;

    // Expected results and the payloads currently handed out.
    typedef struct {
        logic [15:0] addr;
        logic        status;
    } t_expect;
    t_expect     expected_results[$];
    logic [15:0] live_blocks[$];
    int          error_count = 0;
    int          cycle_count = 0;

    function automatic logic [31:0] heap_read(input logic [31:0] a);
        return heap_shadow[(a >> 2) % HW];
    endfunction

    function automatic void heap_write(input logic [31:0] a, input logic [31:0] v);
        heap_shadow[(a >> 2) % HW] = v;
    endfunction

    function automatic logic [31:0] tag_size(input logic [31:0] bp);
        return heap_read(bp - 32'd4) & SIZE_MASK;
    endfunction

    function automatic void list_insert(input logic [31:0] bp);
        heap_write(bp + 32'd4, 32'd0);
        heap_write(bp, shadow_head);
        if (shadow_head != 32'd0) heap_write(shadow_head + 32'd4, bp);
        shadow_head = bp;
    endfunction

    function automatic void list_remove(input logic [31:0] bp);
        logic [31:0] prv;
        logic [31:0] nxt;
        prv = heap_read(bp + 32'd4);
        nxt = heap_read(bp);
        if (prv != 32'd0) heap_write(prv, nxt);
        else shadow_head = nxt;
        if (nxt != 32'd0) heap_write(nxt + 32'd4, prv);
    endfunction

    // Merge a free block with its free neighbors and push it on the list.
    function automatic logic [31:0] coalesce(input logic [31:0] bp_in);
        logic [31:0] bp;
        logic [31:0] sz;
        logic [31:0] pftr;
        logic [31:0] pbp;
        logic [31:0] nbp;
        logic [31:0] nend;
        logic        pa;
        logic        na;
        bp   = bp_in;
        sz   = tag_size(bp);
        pftr = heap_read(bp - 32'd8);
        pbp  = bp - (pftr & SIZE_MASK);
        nbp  = bp + sz;
        pa   = pftr[0];
        na   = ((heap_read(nbp - 32'd4) & ALLOC_BIT) != 32'd0);
        if (pa && !na) begin
            sz += tag_size(nbp);
            list_remove(nbp);
            heap_write(bp - 32'd4, sz);
            heap_write(bp + sz - 32'd8, sz);
        end else if (!pa && na) begin
            sz += tag_size(pbp);
            list_remove(pbp);
            heap_write(bp + tag_size(bp) - 32'd8, sz);
            heap_write(pbp - 32'd4, sz);
            bp = pbp;
        end else if (!pa && !na) begin
            nend = nbp + tag_size(nbp) - 32'd8;
            sz += tag_size(pbp) + tag_size(nbp);
            list_remove(pbp);
            list_remove(nbp);
            heap_write(pbp - 32'd4, sz);
            heap_write(nend, sz);
            bp = pbp;
        end
        list_insert(bp);
        return bp;
    endfunction

    // Extend the heap; zero means the heap is full.
    function automatic logic [31:0] grow_heap(input logic [31:0] bytes);
        logic [31:0] words;
        logic [31:0] sz;
        logic [31:0] bp;
        words = bytes / 4;
        sz = words[0] ? (words + 32'd1) * 4 : words * 4;
        bp = shadow_break;
        if (sz > HW * 4 - shadow_break) return 32'd0;
        shadow_break += sz;
        heap_write(bp - 32'd4, sz);
        heap_write(bp + sz - 32'd8, sz);
        heap_write(bp + sz - 32'd4, ALLOC_BIT);
        return coalesce(bp);
    endfunction

    // Take a free block for an allocation, splitting off a usable remainder.
    function automatic void place_block(input logic [31:0] bp, input logic [31:0] asize);
        logic [31:0] csize;
        logic [31:0] rest;
        csize = tag_size(bp);
        list_remove(bp);
        if (csize - asize >= MIN_BLOCK) begin
            rest = bp + asize;
            heap_write(bp - 32'd4, asize | ALLOC_BIT);
            heap_write(bp + asize - 32'd8, asize | ALLOC_BIT);
            heap_write(rest - 32'd4, csize - asize);
            heap_write(rest + csize - asize - 32'd8, csize - asize);
            list_insert(rest);
        end else begin
            heap_write(bp - 32'd4, csize | ALLOC_BIT);
            heap_write(bp + csize - 32'd8, csize | ALLOC_BIT);
        end
    endfunction

    function automatic logic [31:0] first_fit_alloc(input logic [16:0] req);
        logic [31:0] asize;
        logic [31:0] bp;
        logic [31:0] h;
        logic [31:0] grow_by;
        asize = ({15'd0, req} + 32'd15) & SIZE_MASK;
        bp = shadow_head;
        for (int i = 0; i < HW; i++) begin
            h = heap_read(bp - 32'd4);
            if (h[0]) break;
            if ((h & SIZE_MASK) >= asize) begin
                place_block(bp, asize);
                return bp;
            end
            bp = heap_read(bp);
        end
        grow_by = (asize > shadow_chunk) ? asize : shadow_chunk;
        bp = grow_heap(grow_by);
        if (bp == 32'd0) return 32'd0;
        place_block(bp, asize);
        return bp;
    endfunction

    // A free that fails any sanity check on its address or tags is ignored.
    function automatic void release_block(input logic [31:0] bp);
        logic [31:0] h;
        logic [31:0] sz;
        logic [31:0] unused;
        if (bp[2:0] != 3'd0 || bp < FIRST_PAYLOAD || bp >= shadow_break) return;
        h = heap_read(bp - 32'd4);
        sz = h & SIZE_MASK;
        if (!h[0] || sz < MIN_BLOCK || sz > shadow_break - bp) return;
        if (heap_read(bp + sz - 32'd8) != h) return;
        heap_write(bp - 32'd4, sz);
        heap_write(bp + sz - 32'd8, sz);
        unused = coalesce(bp);
    endfunction

    function automatic void shadow_reset();
        logic [31:0] unused;
        for (int i = 0; i < HW; i++) heap_shadow[i] = 32'd0;
        heap_shadow[1] = MIN_BLOCK | ALLOC_BIT;
        heap_shadow[4] = MIN_BLOCK | ALLOC_BIT;
        heap_shadow[5] = ALLOC_BIT;
        shadow_break = 32'd24;
        shadow_head  = PROLOGUE_PAYLOAD;
        shadow_chunk = INIT_CHUNK;
        unused = grow_heap(INIT_CHUNK);
    endfunction

    function automatic t_expect predict_op(input logic op, input logic [16:0] req,
                                           input logic [15:0] addr);
        t_expect e;
        logic [31:0] r;
        e.addr = 16'd0;
        e.status = ST_DONE;
        if (op == OP_ALLOC) begin
            if (req == 17'd0) begin
                e.status = ST_FAIL;
            end else begin
                r = first_fit_alloc(req);
                e.addr = r[15:0];
                if (r == 32'd0) e.status = ST_FAIL;
            end
        end else begin
            release_block({16'd0, addr});
        end
        return e;
    endfunction

    // Transfer one command; the prediction is made at the accepting edge.
    task automatic send_item(input logic op, input logic [16:0] req, input logic [15:0] addr);
        t_expect e;
        int idx;
        @(negedge i_clk);
        start           = 1'b1;
        i_operation     = op;
        i_request_size  = req;
        i_block_address = addr;
        do @(posedge i_clk); while (busy);
        e = predict_op(op, req, addr);
        expected_results.push_back(e);
        if (op == OP_ALLOC && e.status == ST_DONE) live_blocks.push_back(e.addr);
        if (op == OP_FREE) begin
            for (idx = 0; idx < live_blocks.size(); idx++) begin
                if (live_blocks[idx] == addr) begin
                    live_blocks.delete(idx);
                    break;
                end
            end
        end
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write the growth chunk register while the block is idle.
    task automatic write_chunk(input logic [16:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid          = 1'b1;
        i_extend_chunk_bytes = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_chunk = {15'd0, value};
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result addr=%0d status=%0d", $time,
                         o_result_address, o_status);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_result_address !== e.addr) begin
                    $display("%0t: address mismatch expected=%0d actual=%0d", $time,
                             e.addr, o_result_address);
                    error_count++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                             e.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Zero size, oversize, merge cases and rejected frees.
    task automatic test_directed();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        send_item(OP_ALLOC, 17'd0, 16'hFFFF);
        send_item(OP_ALLOC, 17'd65536, 16'd0);
        send_item(OP_ALLOC, 17'd1, 16'd0);
        a = live_blocks[$];
        send_item(OP_ALLOC, 17'd24, 16'd0);
        b = live_blocks[$];
        send_item(OP_ALLOC, 17'd100, 16'd0);
        c = live_blocks[$];
        send_item(OP_ALLOC, 17'd8, 16'd0);
        d = live_blocks[$];
        send_item(OP_ALLOC, 17'd4000, 16'd0);
        send_item(OP_FREE, 17'h1FFFF, b);
        send_item(OP_FREE, 17'd0, b);
        send_item(OP_FREE, 17'd0, d);
        send_item(OP_FREE, 17'd0, c);
        send_item(OP_FREE, 17'd0, a);
        send_item(OP_FREE, 17'd0, a + 16'd4);
        send_item(OP_FREE, 17'd0, 16'd8);
        send_item(OP_FREE, 17'd0, 16'd16);
        send_item(OP_FREE, 17'd0, 16'hFFF8);
        send_item(OP_FREE, 17'd0, 16'hFFFF);
        send_item(OP_ALLOC, 17'd65535, 16'd0);
        send_item(OP_ALLOC, 17'd30000, 16'd0);
        send_item(OP_FREE, 17'd0, live_blocks[$]);
    endtask

    // Growth with the smallest and largest chunk settings.
    task automatic test_chunk_extremes();
        write_chunk(17'd8);
        for (int i = 0; i < 12; i++) send_item(OP_ALLOC, 17'($urandom_range(1, 3000)), 16'd0);
        while (live_blocks.size() > 0) send_item(OP_FREE, 17'd0, live_blocks.pop_front());
        write_chunk(17'd65536);
        for (int i = 0; i < 6; i++) send_item(OP_ALLOC, 17'($urandom_range(1, 40000)), 16'd0);
        write_chunk(17'h1FFFF);
        send_item(OP_ALLOC, 17'd65536, 16'd0);
        while (live_blocks.size() > 0) send_item(OP_FREE, 17'd0, live_blocks.pop_front());
    endtask

    function automatic logic [16:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 17'($urandom_range(1, 200));
        if (pick < 90) return 17'($urandom_range(1, 4096));
        if (pick < 97) return 17'($urandom_range(4097, 30000));
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [15:0] random_free_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (live_blocks.size() > 0 && pick < 75)
            return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if (live_blocks.size() > 0 && pick < 85)
            return live_blocks[$urandom_range(0, live_blocks.size() - 1)] +
                   16'($urandom_range(0, 15)) - 16'd8;
        return 16'($urandom);
    endfunction

    // Random mix of allocations and frees in bursts, across chunk settings.
    task automatic test_random();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 300 == 150)
                write_chunk(17'($urandom_range(0, 3) == 0 ? $urandom_range(8, 65536)
                                                          : $urandom_range(8, 8192)));
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 99) < 55) send_item(OP_ALLOC, random_size(),
                                                          16'($urandom));
                else send_item(OP_FREE, 17'($urandom), random_free_address());
                sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
            else if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
        end
    endtask

    initial begin
        int wait_count;
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_operation          = OP_ALLOC;
        i_request_size       = 17'd0;
        i_block_address      = 16'd0;
        i_cfg_valid          = 1'b0;
        i_extend_chunk_bytes = EXT_RESET;
        shadow_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_chunk_extremes();
        write_chunk(EXT_RESET);
        test_random();
        write_chunk(17'd8);

        @(negedge i_clk);
        start = 1'b0;
        wait_count = 0;
        while (expected_results.size() != 0 && wait_count < 200000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (64) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
